FILE: rtl/lsri_pkg.sv
`default_nettype none
package lsri_pkg;
  localparam int unsigned CoordWidth = 16;
  localparam int unsigned FracBits   = 4;
  localparam int unsigned KindWidth  = 2;

  typedef enum logic [1:0] {
    KIND_LINE    = 2'd0,
    KIND_SEGMENT = 2'd1,
    KIND_RAY     = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_e;
endpackage
`default_nettype wire

FILE: rtl/lsri_if.sv
`default_nettype none
interface lsri_in_if #(
  parameter int unsigned CW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] first_start_x;
  logic signed [CW-1:0] first_start_y;
  logic signed [CW-1:0] first_end_x;
  logic signed [CW-1:0] first_end_y;
  logic [1:0]           first_kind;
  logic signed [CW-1:0] second_start_x;
  logic signed [CW-1:0] second_start_y;
  logic signed [CW-1:0] second_end_x;
  logic signed [CW-1:0] second_end_y;
  logic [1:0]           second_kind;
  modport source (output valid, first_start_x, first_start_y, first_end_x, first_end_y,
                  first_kind, second_start_x, second_start_y, second_end_x, second_end_y,
                  second_kind, input ready);
  modport sink (input valid, first_start_x, first_start_y, first_end_x, first_end_y,
                first_kind, second_start_x, second_start_y, second_end_x, second_end_y,
                second_kind, output ready);
endinterface

interface lsri_out_if #(
  parameter int unsigned CW = 16
);
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic                 parallel;
  logic signed [CW-1:0] cross_x;
  logic signed [CW-1:0] cross_y;
  logic                 clipped;
  modport source (output valid, hit, parallel, cross_x, cross_y, clipped, input ready);
  modport sink (input valid, hit, parallel, cross_x, cross_y, clipped, output ready);
endinterface
`default_nettype wire

FILE: rtl/lsri_div.sv
`default_nettype none
// Pipelined unsigned restoring divider, one quotient bit per stage.
module lsri_div #(
  parameter int unsigned NW = 51,
  parameter int unsigned DW = 34,
  parameter int unsigned TW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [TW-1:0] tag_i,
  output logic               valid_o,
  output logic [NW-1:0]      quo_o,
  output logic [TW-1:0]      tag_o
);
  logic          v_q   [NW+1];
  logic [NW-1:0] n_q   [NW+1];
  logic [DW:0]   r_q   [NW+1];
  logic [DW-1:0] d_q   [NW+1];
  logic [TW-1:0] t_q   [NW+1];

  always_comb begin
    v_q[0] = valid_i;
    n_q[0] = num_i;
    r_q[0] = '0;
    d_q[0] = den_i;
    t_q[0] = tag_i;
  end

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW+1:0] sh;
    logic [DW+1:0] df;
    logic          v_st_q;
    logic [NW-1:0] n_st_q;
    logic [DW:0]   r_st_q;
    logic [DW-1:0] d_st_q;
    logic [TW-1:0] t_st_q;
    assign sh = {r_q[s], n_q[s][NW-1]};
    assign df = sh - {2'b00, d_q[s]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_st_q <= 1'b0;
      end else if (en_i) begin
        v_st_q <= v_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_st_q <= df[DW+1] ? sh[DW:0] : df[DW:0];
        n_st_q <= {n_q[s][NW-2:0], ~df[DW+1]};
        d_st_q <= d_q[s];
        t_st_q <= t_q[s];
      end
    end
    always_comb begin
      v_q[s+1] = v_st_q;
      n_q[s+1] = n_st_q;
      r_q[s+1] = r_st_q;
      d_q[s+1] = d_st_q;
      t_q[s+1] = t_st_q;
    end
  end

  assign valid_o = v_q[NW];
  assign quo_o   = n_q[NW];
  assign tag_o   = t_q[NW];
endmodule
`default_nettype wire

FILE: rtl/line_segment_ray_intersection_unit.sv
`default_nettype none
// Line/segment/ray intersection, fully pipelined.
// Throughput: one item per cycle; a stall freezes the whole pipe.
// Reset: asynchronous, active low; clears all valid bits, no payload reset.
module line_segment_ray_intersection_unit #(
  parameter int unsigned COORD_WIDTH = lsri_pkg::CoordWidth,
  parameter int unsigned FRAC_BITS   = lsri_pkg::FracBits
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  lsri_in_if.sink  in_i,
  lsri_out_if.source out_o
);
  import lsri_pkg::*;

  // Widths: differences CW+1, products 2CW+2, det/numerators 2CW+3,
  // scaled numerator |n|*|b-a| fits in 3CW+4 bits (magnitude).
  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned VW = CW + 1;
  localparam int unsigned PW = 2*CW + 3;
  localparam int unsigned MW = 3*CW + 4;
  localparam int unsigned QW = MW;
  localparam int unsigned FB = FRAC_BITS;

  // Fraction bits do not affect results: positions are ratios.
  logic unused_frac;
  assign unused_frac = (FB > CW);

  // Global stall: advance when output register free or being taken.
  logic en;
  logic out_v_q;
  assign en       = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  // ---- Stage 1: differences ----
  logic s1_v_q;
  logic signed [VW-1:0] v1x_q, v1y_q, v2x_q, v2y_q, dx_q, dy_q, bax_q, bay_q;
  logic signed [CW-1:0] ax1_s1_q, ay1_s1_q;
  logic [1:0] k1_s1_q, k2_s1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (en) s1_v_q <= in_i.valid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      v1x_q <= VW'(in_i.first_start_x) - VW'(in_i.first_end_x);
      v1y_q <= VW'(in_i.first_start_y) - VW'(in_i.first_end_y);
      v2x_q <= VW'(in_i.second_start_x) - VW'(in_i.second_end_x);
      v2y_q <= VW'(in_i.second_start_y) - VW'(in_i.second_end_y);
      dx_q  <= VW'(in_i.first_start_x) - VW'(in_i.second_start_x);
      dy_q  <= VW'(in_i.first_start_y) - VW'(in_i.second_start_y);
      bax_q <= VW'(in_i.first_end_x) - VW'(in_i.first_start_x);
      bay_q <= VW'(in_i.first_end_y) - VW'(in_i.first_start_y);
      ax1_s1_q <= in_i.first_start_x;
      ay1_s1_q <= in_i.first_start_y;
      k1_s1_q <= in_i.first_kind;
      k2_s1_q <= in_i.second_kind;
    end
  end

  // ---- Stage 2: six products ----
  logic s2_v_q;
  logic signed [2*VW-1:0] p_a_q, p_b_q, p_c_q, p_d_q, p_e_q, p_f_q;
  logic signed [VW-1:0] bax_s2_q, bay_s2_q;
  logic signed [CW-1:0] ax1_s2_q, ay1_s2_q;
  logic [1:0] k1_s2_q, k2_s2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (en) s2_v_q <= s1_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_a_q <= v2y_q * v1x_q;
      p_b_q <= v1y_q * v2x_q;
      p_c_q <= dx_q * v2y_q;
      p_d_q <= dy_q * v2x_q;
      p_e_q <= dx_q * v1y_q;
      p_f_q <= dy_q * v1x_q;
      bax_s2_q <= bax_q; bay_s2_q <= bay_q;
      ax1_s2_q <= ax1_s1_q; ay1_s2_q <= ay1_s1_q;
      k1_s2_q <= k1_s1_q; k2_s2_q <= k2_s1_q;
    end
  end

  // ---- Stage 3: determinant and numerators, normalize sign ----
  logic signed [PW-1:0] det_c, n1_c, n2_c;
  assign det_c = PW'(p_a_q) - PW'(p_b_q);
  assign n1_c  = PW'(p_c_q) - PW'(p_d_q);
  assign n2_c  = PW'(p_e_q) - PW'(p_f_q);

  logic s3_v_q;
  logic signed [PW-1:0] det_q, n1_q, n2_q;
  logic signed [VW-1:0] bax_s3_q, bay_s3_q;
  logic signed [CW-1:0] ax1_s3_q, ay1_s3_q;
  logic [1:0] k1_s3_q, k2_s3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else if (en) s3_v_q <= s2_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      det_q <= det_c[PW-1] ? -det_c : det_c;
      n1_q  <= det_c[PW-1] ? -n1_c  : n1_c;
      n2_q  <= det_c[PW-1] ? -n2_c  : n2_c;
      bax_s3_q <= bax_s2_q; bay_s3_q <= bay_s2_q;
      ax1_s3_q <= ax1_s2_q; ay1_s3_q <= ay1_s2_q;
      k1_s3_q <= k1_s2_q; k2_s3_q <= k2_s2_q;
    end
  end

  // ---- Stage 4: kind checks, parallel, magnitude products ----
  function automatic logic kind_ok(input logic [1:0] k, input logic signed [PW-1:0] n,
                                   input logic signed [PW-1:0] d);
    logic r;
    case (kind_e'(k))
      KIND_LINE:    r = 1'b1;
      KIND_SEGMENT: r = !n[PW-1] && (n <= d);
      KIND_RAY:     r = !n[PW-1];
      default:      r = 1'b0;
    endcase
    return r;
  endfunction

  logic par_c, hit_c;
  logic [PW-1:0] n1mag_c;
  logic [VW-1:0] bxmag_c, bymag_c;
  assign par_c   = (det_q == '0);
  assign hit_c   = !par_c && kind_ok(k1_s3_q, n1_q, det_q) && kind_ok(k2_s3_q, n2_q, det_q);
  assign n1mag_c = n1_q[PW-1] ? PW'(-n1_q) : PW'(n1_q);
  assign bxmag_c = bax_s3_q[VW-1] ? VW'(-bax_s3_q) : VW'(bax_s3_q);
  assign bymag_c = bay_s3_q[VW-1] ? VW'(-bay_s3_q) : VW'(bay_s3_q);

  logic s4_v_q, par4_q, hit4_q, negx4_q, negy4_q;
  logic [MW-1:0] mx4_q, my4_q;
  logic [PW-1:0] det4_q;
  logic signed [CW-1:0] ax1_s4_q, ay1_s4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_v_q <= 1'b0;
    else if (en) s4_v_q <= s3_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      par4_q <= par_c;
      hit4_q <= hit_c;
      mx4_q  <= MW'(n1mag_c) * MW'(bxmag_c);
      my4_q  <= MW'(n1mag_c) * MW'(bymag_c);
      negx4_q <= n1_q[PW-1] ^ bax_s3_q[VW-1];
      negy4_q <= n1_q[PW-1] ^ bay_s3_q[VW-1];
      det4_q <= par_c ? PW'(1) : det_q;
      ax1_s4_q <= ax1_s3_q; ay1_s4_q <= ay1_s3_q;
    end
  end

  // ---- Divider lanes: x and y quotient magnitudes ----
  localparam int unsigned TGW = 4 + 2*CW;
  logic [TGW-1:0] tag_in, tag_out;
  assign tag_in = {par4_q, hit4_q, negx4_q, negy4_q, ax1_s4_q, ay1_s4_q};
  logic dvx_v, dvy_v;
  logic [QW-1:0] qx, qy;
  logic [TGW-1:0] tag_y_unused;

  lsri_div #(.NW(QW), .DW(PW), .TW(TGW)) u_div_x (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s4_v_q), .num_i(mx4_q), .den_i(det4_q),
    .tag_i(tag_in), .valid_o(dvx_v), .quo_o(qx), .tag_o(tag_out)
  );
  lsri_div #(.NW(QW), .DW(PW), .TW(TGW)) u_div_y (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s4_v_q), .num_i(my4_q), .den_i(det4_q),
    .tag_i(tag_in), .valid_o(dvy_v), .quo_o(qy), .tag_o(tag_y_unused)
  );

  logic par_d, hit_d, negx_d, negy_d;
  logic signed [CW-1:0] ax_d, ay_d;
  assign {par_d, hit_d, negx_d, negy_d, ax_d, ay_d} = tag_out;

  // ---- Stage 5: apply sign, add start point ----
  localparam int unsigned SW = QW + 2;
  logic signed [SW-1:0] sx_c, sy_c;
  assign sx_c = SW'(signed'(ax_d)) + (negx_d ? -SW'(qx) : SW'(qx));
  assign sy_c = SW'(signed'(ay_d)) + (negy_d ? -SW'(qy) : SW'(qy));

  logic s5_v_q, par5_q, hit5_q;
  logic signed [SW-1:0] sx5_q, sy5_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s5_v_q <= 1'b0;
    else if (en) s5_v_q <= dvx_v && dvy_v && (tag_y_unused == tag_out);
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      par5_q <= par_d; hit5_q <= hit_d;
      sx5_q <= sx_c; sy5_q <= sy_c;
    end
  end

  // ---- Stage 6: saturate, output register ----
  localparam logic signed [SW-1:0] Top = SW'((64'sd1 <<< (CW-1)) - 64'sd1);
  localparam logic signed [SW-1:0] Bot = -SW'(64'sd1 <<< (CW-1));
  logic ovx, unx, ovy, uny;
  assign ovx = sx5_q > Top;
  assign unx = sx5_q < Bot;
  assign ovy = sy5_q > Top;
  assign uny = sy5_q < Bot;

  logic hit_q, par_q, clip_q;
  logic signed [CW-1:0] cx_q, cy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= s5_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q  <= hit5_q;
      par_q  <= par5_q;
      clip_q <= hit5_q && (ovx || unx || ovy || uny);
      cx_q   <= !hit5_q ? '0 : ovx ? CW'(Top) : unx ? CW'(Bot) : CW'(sx5_q);
      cy_q   <= !hit5_q ? '0 : ovy ? CW'(Top) : uny ? CW'(Bot) : CW'(sy5_q);
    end
  end

  assign out_o.valid    = out_v_q;
  assign out_o.hit      = hit_q;
  assign out_o.parallel = par_q;
  assign out_o.cross_x  = cx_q;
  assign out_o.cross_y  = cy_q;
  assign out_o.clipped  = clip_q;
endmodule
`default_nettype wire
